FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the lever button event generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on clk, switched off while arst_n is low.
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked on clk at every edge, also during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/lbeg_pkg.sv
// Types, codes and helpers of the lever button event generator.
`default_nettype none
package lbeg_pkg;

	// Event codes
	typedef enum logic [2:0] {
		EV_DOWN  = 3'd0,
		EV_UP    = 3'd1,
		EV_CLICK = 3'd2,
		EV_TICK  = 3'd3,
		EV_LONG  = 3'd4
	} event_type_t;

	// Button codes
	localparam logic [1:0] BTN_TOUCH  = 2'd0;
	localparam logic [1:0] BTN_LEFT   = 2'd1;
	localparam logic [1:0] BTN_CENTER = 2'd2;
	localparam logic [1:0] BTN_RIGHT  = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_POLARITY = 2'd0;
	localparam logic [1:0] REG_DELAY    = 2'd1;
	localparam logic [1:0] REG_INTERVAL = 2'd2;

	localparam int NUM_LEVERS = 3;
	localparam int CENTER_LEVER = 1;
	// Event slots of one sample: touch, then two per lever
	localparam int NUM_SLOTS = 1 + 2 * NUM_LEVERS;
	localparam int SLOT_W = $clog2(NUM_SLOTS);

	// Hold counter: zero or more counts held samples, negative marks repeat phase
	typedef logic signed [16:0] hold_t;
	localparam hold_t HOLD_REPEAT    = -17'sd1;
	localparam hold_t HOLD_LONG_DONE = -17'sd2;

	// Events of one sample, handed from front to back
	typedef struct packed {
		logic [NUM_SLOTS-1:0]      valid;
		logic [NUM_SLOTS-1:0][2:0] kind;
	} desc_t;

	// Queue status towards both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Button owning a slot: touch in slot 0, each lever owns two slots
	function automatic logic [1:0] slot_button(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W:0] sum;
		sum = {1'b0, idx} + {{SLOT_W{1'b0}}, 1'b1};
		return sum[2:1];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lbeg_front.sv
// Front end: configuration, press detection, hold counters and event classification.
`default_nettype none
module lbeg_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [15:0]       wr_data,
	input  wire logic              touch_level,
	input  wire logic              left_level,
	input  wire logic              center_level,
	input  wire logic              right_level,
	input  wire logic              push,
	input  wire logic              q_full,
	output logic                   q_push,
	output lbeg_pkg::desc_t        desc
);

	logic        polarity_q;
	logic [15:0] delay_q;
	logic [15:0] interval_q;
	logic [3:0]  prev_q;
	lbeg_pkg::hold_t hold_q [lbeg_pkg::NUM_LEVERS];
	lbeg_pkg::hold_t hold_nxt [lbeg_pkg::NUM_LEVERS];
	logic [3:0]  now;
	logic        accept;

	assign accept = push && !q_full;
	assign q_push = accept && (|desc.valid);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q <= 1'b1;
			delay_q    <= 16'd50;
			interval_q <= 16'd10;
		end else if (wr_en) begin
			unique case (wr_index)
				lbeg_pkg::REG_POLARITY: polarity_q <= wr_data[0];
				lbeg_pkg::REG_DELAY:    delay_q    <= wr_data;
				lbeg_pkg::REG_INTERVAL: interval_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Classify the sample into event slots and work out the next counters
	always_comb begin
		logic [2:0]      lev;
		lbeg_pkg::hold_t c;
		lbeg_pkg::hold_t cm;
		lbeg_pkg::hold_t cp;
		lbeg_pkg::hold_t neg_int;
		lbeg_pkg::hold_t delay_s;
		logic            pr;
		logic            chg;
		lev     = {right_level, center_level, left_level};
		neg_int = -$signed({1'b0, interval_q});
		delay_s = $signed({1'b0, delay_q});
		now[0]  = ~touch_level;
		for (int i = 0; i < lbeg_pkg::NUM_LEVERS; i++) begin
			now[i+1] = (lev[i] == polarity_q);
		end
		desc.valid = '0;
		desc.kind  = '0;
		desc.valid[0] = now[0] ^ prev_q[0];
		desc.kind[0]  = now[0] ? lbeg_pkg::EV_DOWN : lbeg_pkg::EV_UP;
		for (int i = 0; i < lbeg_pkg::NUM_LEVERS; i++) begin
			c   = hold_q[i];
			pr  = now[i+1];
			chg = now[i+1] ^ prev_q[i+1];
			cm  = c - 17'sd1;
			cp  = c + 17'sd1;
			desc.valid[1+2*i] = chg;
			desc.kind[1+2*i]  = pr ? lbeg_pkg::EV_DOWN : lbeg_pkg::EV_UP;
			hold_nxt[i] = c;
			// click on a release that never reached the repeat phase
			if (chg && !pr && (c >= 17'sd0)) begin
				desc.valid[2+2*i] = 1'b1;
				desc.kind[2+2*i]  = lbeg_pkg::EV_CLICK;
			end
			if (pr) begin
				if (c < 17'sd0) begin
					if (i != lbeg_pkg::CENTER_LEVER) begin
						if (cm <= neg_int) begin
							desc.valid[2+2*i] = 1'b1;
							desc.kind[2+2*i]  = lbeg_pkg::EV_TICK;
							hold_nxt[i] = lbeg_pkg::HOLD_REPEAT;
						end else begin
							hold_nxt[i] = cm;
						end
					end else if (c == lbeg_pkg::HOLD_REPEAT) begin
						desc.valid[2+2*i] = 1'b1;
						desc.kind[2+2*i]  = lbeg_pkg::EV_LONG;
						hold_nxt[i] = lbeg_pkg::HOLD_LONG_DONE;
					end
				end else begin
					hold_nxt[i] = (cp >= delay_s) ? lbeg_pkg::HOLD_REPEAT : cp;
				end
			end else begin
				hold_nxt[i] = '0;
			end
		end
	end

	// Per-sample state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			for (int i = 0; i < lbeg_pkg::NUM_LEVERS; i++) begin
				hold_q[i] <= '0;
			end
		end else if (accept) begin
			prev_q <= now;
			for (int i = 0; i < lbeg_pkg::NUM_LEVERS; i++) begin
				hold_q[i] <= hold_nxt[i];
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/lbeg_queue.sv
// Short queue of per-sample event words between front and back.
`default_nettype none
module lbeg_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lbeg_pkg::desc_t wdata,
	input  wire logic            pop,
	output lbeg_pkg::desc_t      rdata,
	output lbeg_pkg::q_status_t  status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	lbeg_pkg::desc_t   store_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign rdata   = store_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/lbeg_back.sv
// Back end: emits the events of one sample word in slot order into the result register.
`default_nettype none
module lbeg_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lbeg_pkg::desc_t q_rdata,
	input  wire logic            q_empty,
	output logic                 q_pop,
	input  wire logic            pop,
	output logic                 empty,
	output logic [1:0]           event_button,
	output logic [2:0]           event_type,
	output logic                 last_of_tick
);

	logic [lbeg_pkg::NUM_SLOTS-1:0]      work_valid_q;
	logic [lbeg_pkg::NUM_SLOTS-1:0][2:0] work_kind_q;
	logic                                out_valid_q;
	logic [1:0]                          out_button_q;
	logic [2:0]                          out_type_q;
	logic                                out_last_q;
	logic [lbeg_pkg::SLOT_W-1:0]         sel;
	logic [lbeg_pkg::NUM_SLOTS-1:0]      rest;
	logic                                take;
	logic                                emit;

	// Lowest pending slot and what remains after it
	always_comb begin
		sel = '0;
		for (int i = lbeg_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (work_valid_q[i]) begin
				sel = lbeg_pkg::SLOT_W'(i);
			end
		end
		rest = work_valid_q;
		rest[sel] = 1'b0;
	end

	assign take  = !out_valid_q || pop;
	assign emit  = take && (|work_valid_q);
	assign q_pop = !q_empty && (!(|work_valid_q) || (emit && (rest == '0)));

	// Working word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= '0;
		end else if (q_pop) begin
			work_valid_q <= q_rdata.valid;
		end else if (emit) begin
			work_valid_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_kind_q <= q_rdata.kind;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_button_q <= lbeg_pkg::slot_button(sel);
			out_type_q   <= work_kind_q[sel];
			out_last_q   <= (rest == '0);
		end
	end

	assign empty        = !out_valid_q;
	assign event_button = out_button_q;
	assign event_type   = out_type_q;
	assign last_of_tick = out_last_q;

endmodule
`default_nettype wire

FILE: hw/rtl/lever_button_event_generator.sv
// Top level of the lever button event generator.
// Each pushed word is one debounced sample of the touch line and the three lever lines; it
// yields zero to seven result words (touch, left, center, right order), the final one of a
// sample flagged by last_of_tick. The front end takes one sample per cycle while its queue
// of QUEUE_DEPTH sample words (2 or more) has room; a sample without events takes no slot.
// The back end sends one result word per cycle into a one-word result register while it is
// free or being popped, and loads the next sample word when its working word has run dry or
// as it emits the last event of a word. A pushed sample passes the queue, the working word
// and the result register. Configuration: wr_en with wr_index 0 polarity, 1 tick delay, 2
// tick interval; write only while no results are pending.
`default_nettype none
`include "assert_macros.svh"
module lever_button_event_generator #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [15:0] wr_data,
	input  wire logic        touch_level,
	input  wire logic        left_level,
	input  wire logic        center_level,
	input  wire logic        right_level,
	input  wire logic        push,
	output logic             full,
	output logic [1:0]       event_button,
	output logic [2:0]       event_type,
	output logic             last_of_tick,
	output logic             empty,
	input  wire logic        pop
);

	lbeg_pkg::desc_t     front_desc;
	lbeg_pkg::desc_t     q_rdata;
	lbeg_pkg::q_status_t q_status;
	logic                q_push;
	logic                q_pop;
	logic                touch_kind_ok;
	logic                tick_side_ok;
	logic                long_side_ok;

	assign full = q_status.full;

	// Front end
	lbeg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.touch_level  (touch_level),
		.left_level   (left_level),
		.center_level (center_level),
		.right_level  (right_level),
		.push         (push),
		.q_full       (q_status.full),
		.q_push       (q_push),
		.desc         (front_desc)
	);

	// Sample word queue
	lbeg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (front_desc),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	// Back end
	lbeg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_rdata      (q_rdata),
		.q_empty      (q_status.empty),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.event_button (event_button),
		.event_type   (event_type),
		.last_of_tick (last_of_tick)
	);

	// Kind rules of the word on the result ports
	assign touch_kind_ok = (event_button != lbeg_pkg::BTN_TOUCH) ||
		(event_type == lbeg_pkg::EV_DOWN) || (event_type == lbeg_pkg::EV_UP);
	assign tick_side_ok = (event_type != lbeg_pkg::EV_TICK) ||
		(event_button == lbeg_pkg::BTN_LEFT) || (event_button == lbeg_pkg::BTN_RIGHT);
	assign long_side_ok = (event_type != lbeg_pkg::EV_LONG) ||
		(event_button == lbeg_pkg::BTN_CENTER);

	// Checks
	`ASSERT_RST(a_burst_continues, (!empty && pop && !last_of_tick) |=> !empty, "burst broken")
	`ASSERT_RST(a_touch_kind, !empty |-> touch_kind_ok, "touch event of bad kind")
	`ASSERT_RST(a_tick_side, !empty |-> tick_side_ok, "tick on wrong button")
	`ASSERT_RST(a_long_center, !empty |-> long_side_ok, "long press on wrong button")
	`ASSERT_ALWAYS(a_qpop_legal, q_pop |-> !q_status.empty, "queue read while empty")

endmodule
`default_nettype wire
